// ----- src/tpm_pkg.sv -----
// Package with the constants and types of the per-user throughput meter.
package tpm_pkg;

	localparam int unsigned TABLE_DEPTH = 64;
	localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
	localparam int unsigned ID_W        = 16;
	localparam int unsigned BYTES_W     = 32;
	localparam int unsigned TIME_W      = 52;
	localparam int unsigned RATE_W      = 35;
	localparam int unsigned FRAC_SHIFT  = 19;
	localparam int unsigned NUM_W       = BYTES_W + FRAC_SHIFT;
	localparam int unsigned ENTRY_W     = BYTES_W + TIME_W;
	localparam int unsigned DIV_STEPS   = RATE_W;
	localparam int unsigned CNT_W       = $clog2(DIV_STEPS + 1);

	localparam logic [BYTES_W-1:0] MIN_INTERVAL_RESET = 32'd100000;
	localparam logic [RATE_W-1:0]  RATE_MAX           = {RATE_W{1'b1}};

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_EVAL = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

endpackage

// ----- src/tpm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module tpm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/per_ue_throughput_meter.sv -----
// Top level of the per-user uplink throughput meter with its bit-serial divider.
// A report passes READ and EVAL; one that yields a result then runs the divider in DIV
// (skipped when the rate saturates) and shows it from FIN; one without a result ends in EVAL.
// A new report is taken only once the last one is done; the divider is a 35-step restoring divider.
// Reset clears the entry valid bits at once, so the whole table reads as unused,
// and loads the interval register with 100000; the table RAM itself is not cleared.
module per_ue_throughput_meter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tpm_pkg::BYTES_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tpm_pkg::ID_W-1:0]      ue_id,
	input  logic [tpm_pkg::BYTES_W-1:0]   total_bytes,
	input  logic [tpm_pkg::TIME_W-1:0]    now_us,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tpm_pkg::ID_W-1:0]      user_id,
	output logic [tpm_pkg::RATE_W-1:0]    rate_mbps_q16
);

	tpm_pkg::state_t                   state_q;
	logic [tpm_pkg::BYTES_W-1:0]       interval_q;
	logic [tpm_pkg::TABLE_DEPTH-1:0]   valid_q;
	logic [tpm_pkg::CNT_W-1:0]         cnt_q;
	logic                              out_valid_q;
	logic                              ent_valid_q;

	logic [tpm_pkg::ID_W-1:0]          id_q;
	logic [tpm_pkg::BYTES_W-1:0]       bytes_q;
	logic [tpm_pkg::TIME_W-1:0]        now_q;
	logic [tpm_pkg::TIME_W-1:0]        elapsed_q;
	logic [tpm_pkg::BYTES_W-1:0]       diff_q;
	logic                              unused_q;
	logic                              back_q;
	logic [tpm_pkg::TIME_W-1:0]        rem_q;
	logic [tpm_pkg::RATE_W-1:0]        num_q;
	logic [tpm_pkg::RATE_W-1:0]        quo_q;
	logic [tpm_pkg::ID_W-1:0]          user_id_q;
	logic [tpm_pkg::RATE_W-1:0]        rate_q;

	logic                              accept;
	logic                              out_free;
	logic [tpm_pkg::IDX_W-1:0]         slot;
	logic [tpm_pkg::ENTRY_W-1:0]       rdata;
	logic [tpm_pkg::BYTES_W-1:0]       stored_bytes;
	logic [tpm_pkg::TIME_W-1:0]        stored_time;
	logic [tpm_pkg::TIME_W:0]          time_diff;
	logic [tpm_pkg::TIME_W-1:0]        eff_interval;
	logic                              too_short;
	logic                              ram_we;
	logic [tpm_pkg::NUM_W-1:0]         num_full;
	logic [tpm_pkg::TIME_W-1:0]        rem_init;
	logic                              overflow;
	logic [tpm_pkg::TIME_W:0]          rem_shift;
	logic [tpm_pkg::TIME_W:0]          rem_sub;
	logic                              quo_bit;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != tpm_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign slot      = (state_q == tpm_pkg::ST_IDLE) ? ue_id[tpm_pkg::IDX_W-1:0]
	                                                 : id_q[tpm_pkg::IDX_W-1:0];

	assign stored_bytes = ent_valid_q ? rdata[tpm_pkg::ENTRY_W-1:tpm_pkg::TIME_W]
	                                  : '0;
	assign stored_time  = ent_valid_q ? rdata[tpm_pkg::TIME_W-1:0] : '0;
	assign time_diff    = {1'b0, now_q} - {1'b0, stored_time};

	assign eff_interval = (interval_q == '0) ? tpm_pkg::TIME_W'(1)
	                                         : tpm_pkg::TIME_W'(interval_q);
	assign too_short    = elapsed_q < eff_interval;

	assign num_full = {diff_q, {tpm_pkg::FRAC_SHIFT{1'b0}}};
	assign rem_init = tpm_pkg::TIME_W'(num_full[tpm_pkg::NUM_W-1:tpm_pkg::RATE_W]);
	assign overflow = rem_init >= elapsed_q;

	assign rem_shift = {rem_q, num_q[tpm_pkg::RATE_W-1]};
	assign quo_bit   = rem_shift >= {1'b0, elapsed_q};
	assign rem_sub   = rem_shift - {1'b0, elapsed_q};

	assign ram_we = (state_q == tpm_pkg::ST_EVAL) && (unused_q || (!back_q && !too_short));

	tpm_ram #(
		.WIDTH(tpm_pkg::ENTRY_W),
		.DEPTH(tpm_pkg::TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(id_q[tpm_pkg::IDX_W-1:0]),
		.wdata({bytes_q, now_q}),
		.re   (accept),
		.raddr(slot),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tpm_pkg::ST_IDLE;
			interval_q  <= tpm_pkg::MIN_INTERVAL_RESET;
			valid_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			ent_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				interval_q <= cfg_data;
			end
			if (accept) begin
				ent_valid_q <= valid_q[slot];
			end
			if (ram_we) begin
				valid_q[id_q[tpm_pkg::IDX_W-1:0]] <= 1'b1;
			end
			if ((state_q == tpm_pkg::ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				tpm_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= tpm_pkg::ST_READ;
					end
				end
				tpm_pkg::ST_READ: begin
					state_q <= tpm_pkg::ST_EVAL;
				end
				tpm_pkg::ST_EVAL: begin
					if (unused_q || back_q || too_short) begin
						state_q <= tpm_pkg::ST_IDLE;
					end else if (overflow) begin
						state_q <= tpm_pkg::ST_FIN;
					end else begin
						cnt_q   <= tpm_pkg::CNT_W'(tpm_pkg::DIV_STEPS);
						state_q <= tpm_pkg::ST_DIV;
					end
				end
				tpm_pkg::ST_DIV: begin
					cnt_q <= cnt_q - tpm_pkg::CNT_W'(1);
					if (cnt_q == tpm_pkg::CNT_W'(1)) begin
						state_q <= tpm_pkg::ST_FIN;
					end
				end
				tpm_pkg::ST_FIN: begin
					if (out_free) begin
						state_q <= tpm_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tpm_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q    <= ue_id;
			bytes_q <= total_bytes;
			now_q   <= now_us;
		end
		if (state_q == tpm_pkg::ST_READ) begin
			elapsed_q <= time_diff[tpm_pkg::TIME_W-1:0];
			back_q    <= time_diff[tpm_pkg::TIME_W];
			unused_q  <= (stored_time == '0);
			diff_q    <= bytes_q - stored_bytes;
		end
		if (state_q == tpm_pkg::ST_EVAL) begin
			rem_q <= rem_init;
			num_q <= num_full[tpm_pkg::RATE_W-1:0];
			quo_q <= overflow ? tpm_pkg::RATE_MAX : '0;
		end
		if (state_q == tpm_pkg::ST_DIV) begin
			rem_q <= quo_bit ? rem_sub[tpm_pkg::TIME_W-1:0] : rem_shift[tpm_pkg::TIME_W-1:0];
			num_q <= {num_q[tpm_pkg::RATE_W-2:0], 1'b0};
			quo_q <= {quo_q[tpm_pkg::RATE_W-2:0], quo_bit};
		end
		if ((state_q == tpm_pkg::ST_FIN) && out_free) begin
			user_id_q <= id_q;
			rate_q    <= quo_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign user_id       = user_id_q;
	assign rate_mbps_q16 = rate_q;

endmodule

// ----- src/tpm_checker.sv -----
// Port-level assertion checker for the throughput meter and its bind statement.
module tpm_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [tpm_pkg::ID_W-1:0]      user_id,
	input  logic [tpm_pkg::RATE_W-1:0]    rate_mbps_q16
);

	// A stalled result transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(user_id) && $stable(rate_mbps_q16))
		else $error("result changed while stalled");

	// The meter works on one report at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a transaction");

	// A new result is only loaded while a report is being processed.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a report in progress");

	// The register port never pushes back.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind per_ue_throughput_meter tpm_checker u_tpm_checker (.*);
